>>> src/tcpcs_pkg.sv
// Shared types, constants and ones'-complement helpers for the TCP checksum block.
// Used by tcpcs_finish and tcp_checksum_with_pseudo_header_top; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tcpcs_pkg;

  localparam int unsigned WordW  = 16;
  localparam int unsigned CountW = 17;
  localparam int unsigned AddrW  = 32;
  localparam int unsigned OutDataW = 40;

  localparam logic [CountW-1:0] FieldOffset = 17'd16;
  localparam logic [CountW-1:0] CountMax    = 17'h1ffff;
  localparam logic [WordW-1:0]  ProtoTcp    = 16'd6;

  // Configuration register indexes.
  localparam logic RegSrcAddr = 1'b0;
  localparam logic RegDstAddr = 1'b1;

  // Totals of one segment, handed from the accumulator to the finishing stage.
  typedef struct packed {
    logic [WordW-1:0]  sum;
    logic [CountW-1:0] count;
    logic [WordW-1:0]  field;
  } fin_t;

  // Ones'-complement add of two 16-bit words with end-around carry.
  function automatic logic [WordW-1:0] oc_add(input logic [WordW-1:0] a,
                                              input logic [WordW-1:0] b);
    logic [WordW:0] s;
    logic [WordW:0] f;
    begin
      s = {1'b0, a} + {1'b0, b};
      f = {1'b0, s[WordW-1:0]} + {{WordW{1'b0}}, s[WordW]};
      oc_add = f[WordW-1:0];
    end
  endfunction

  // Folds an 18-bit sum of up to four 16-bit terms back into 16 bits.
  function automatic logic [WordW-1:0] fold18(input logic [WordW+1:0] v);
    logic [WordW:0] f1;
    logic [WordW:0] f2;
    begin
      f1 = {1'b0, v[WordW-1:0]} + {{(WordW-1){1'b0}}, v[WordW+1:WordW]};
      f2 = {1'b0, f1[WordW-1:0]} + {{WordW{1'b0}}, f1[WordW]};
      fold18 = f2[WordW-1:0];
    end
  endfunction

endpackage

`default_nettype wire

>>> src/tcpcs_finish.sv
// Finishing stage: adds pseudo header and length, inverts, compares, and holds the result.
// Depends on tcpcs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcpcs_finish (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             fin_valid_i,
  input  wire tcpcs_pkg::fin_t                  fin_i,
  input  wire logic [tcpcs_pkg::WordW-1:0]      pseudo_i,
  output logic                                  fin_ready_o,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // checksum[15:0], received_field[31:16], matches_res[32], too_long[33], zeros above
  output logic [tcpcs_pkg::OutDataW-1:0]        m_axis_tdata
);
  import tcpcs_pkg::*;

  logic                 out_valid_q;
  logic [OutDataW-1:0]  out_data_q;
  logic [OutDataW-1:0]  out_data_d;
  logic [WordW+1:0]     total;
  logic [WordW-1:0]     folded;
  logic [WordW-1:0]     chk;

  // Three terms: running sum, precomputed address/protocol sum, low length bits.
  assign total  = {2'b00, fin_i.sum} + {2'b00, pseudo_i} + {2'b00, fin_i.count[WordW-1:0]};
  assign folded = fold18(total);
  assign chk    = ~folded;

  assign out_data_d = {6'b0, fin_i.count[WordW], (chk == fin_i.field), fin_i.field, chk};

  assign fin_ready_o = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin_ready_o) begin
      out_valid_q <= fin_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_ready_o && fin_valid_i) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

>>> src/tcp_checksum_with_pseudo_header_top.sv
// Top level of the TCP checksum block: input register, accumulator, segment totals, finishing stage.
// Depends on tcpcs_pkg and tcpcs_finish.
`timescale 1ns / 1ps
`default_nettype none

// Usage
// The segment enters on the slave stream one 16-bit word per transfer, first byte
// in the high half of s_axis_tdata. s_axis_tuser is high when both bytes are
// valid and low when only the high byte is, which is meant for the final word.
// s_axis_tlast marks the final word of a segment. For every last word the master
// stream delivers one transfer holding the checksum (the field taken as zero),
// the checksum field seen at byte offset 16, a match flag, and a flag for a
// segment longer than 65535 bytes. Words without tlast produce no transfer.
// The addresses of the pseudo header are written on the configuration port
// (index 0 source, index 1 destination) while no segment is in flight.
// The input register loads the last word at the edge that accepts it; from there it moves
// to the segment totals register and on to the finishing stage, which folds in the pseudo
// header, and m_axis_tvalid rises when the finishing stage loads.
// One word is accepted every cycle while s_axis_tready is high; the 16-bit
// end-around-carry adder of the running sum and the byte counter form the loops.
// Reset clears all valid flags, the running sum, byte count, saved field and
// address registers. When the receiver stalls, a finished result waits in the
// output register while the stages behind it keep filling, and s_axis_tready
// drops only once a waiting last word has no free stage to move into.

module tcp_checksum_with_pseudo_header_top (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic                              cfg_idx_i,
  input  wire logic [tcpcs_pkg::AddrW-1:0]       cfg_wdata_i,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // data_word[15:0]
  input  wire logic [tcpcs_pkg::WordW-1:0]       s_axis_tdata,
  // two_bytes[0]
  input  wire logic [0:0]                        s_axis_tuser,
  input  wire logic                              s_axis_tlast,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // checksum[15:0], received_field[31:16], matches_res[32], too_long[33], zeros above
  output logic [tcpcs_pkg::OutDataW-1:0]         m_axis_tdata
);
  import tcpcs_pkg::*;

  // Configuration and the precomputed pseudo header sum (addresses plus protocol).
  logic [AddrW-1:0] src_q;
  logic [AddrW-1:0] dst_q;
  logic [WordW-1:0] pseudo_q;
  logic [WordW-1:0] pseudo_d;
  logic [WordW+1:0] pseudo_total;

  // Input register.
  logic             in_valid_q;
  logic [WordW-1:0] in_word_q;
  logic             in_both_q;
  logic             in_last_q;

  // Accumulator state.
  logic [WordW-1:0]  sum_q,   sum_d;
  logic [CountW-1:0] cnt_q,   cnt_d;
  logic [WordW-1:0]  field_q, field_d;

  // Segment totals waiting for the finishing stage.
  logic fin_valid_q;
  fin_t fin_q;
  logic fin_ready;
  logic fin_load;

  logic              accum_fire;
  logic [WordW-1:0]  word_m;
  logic              field_hit;
  logic [WordW-1:0]  sum_new;
  logic [WordW-1:0]  field_new;
  logic [CountW:0]   cnt_inc;
  logic [CountW-1:0] cnt_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_q <= '0;
      dst_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegSrcAddr: src_q <= cfg_wdata_i;
        RegDstAddr: dst_q <= cfg_wdata_i;
        default:    src_q <= src_q;
      endcase
    end
  end

  assign pseudo_total = {2'b00, src_q[AddrW-1:WordW]} + {2'b00, src_q[WordW-1:0]}
                      + {2'b00, dst_q[AddrW-1:WordW]} + {2'b00, dst_q[WordW-1:0]};
  assign pseudo_d = oc_add(fold18(pseudo_total), ProtoTcp);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pseudo_q <= ProtoTcp;
    end else begin
      pseudo_q <= pseudo_d;
    end
  end

  // A last word needs a free totals register; other words always move on.
  assign fin_load   = in_valid_q && in_last_q && (!fin_valid_q || fin_ready);
  assign accum_fire = in_valid_q && (!in_last_q || !fin_valid_q || fin_ready);
  assign s_axis_tready = !in_valid_q || accum_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_word_q <= s_axis_tdata;
      in_both_q <= s_axis_tuser[0];
      in_last_q <= s_axis_tlast;
    end
  end

  // A lone byte is padded with a zero low byte.
  assign word_m    = in_both_q ? in_word_q : {in_word_q[WordW-1:8], 8'h00};
  assign field_hit = (cnt_q == FieldOffset);
  assign sum_new   = field_hit ? sum_q : oc_add(sum_q, word_m);
  assign field_new = field_hit ? word_m : field_q;
  assign cnt_inc   = {1'b0, cnt_q} + (in_both_q ? 18'd2 : 18'd1);
  assign cnt_new   = (cnt_inc > {1'b0, CountMax}) ? CountMax : cnt_inc[CountW-1:0];

  always_comb begin
    sum_d   = sum_q;
    cnt_d   = cnt_q;
    field_d = field_q;
    if (accum_fire) begin
      if (in_last_q) begin
        sum_d   = '0;
        cnt_d   = '0;
        field_d = '0;
      end else begin
        sum_d   = sum_new;
        cnt_d   = cnt_new;
        field_d = field_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      cnt_q   <= '0;
      field_q <= '0;
    end else begin
      sum_q   <= sum_d;
      cnt_q   <= cnt_d;
      field_q <= field_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_valid_q <= 1'b0;
    end else if (!fin_valid_q || fin_ready) begin
      fin_valid_q <= fin_load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_load) begin
      fin_q.sum   <= sum_new;
      fin_q.count <= cnt_new;
      fin_q.field <= field_new;
    end
  end

  tcpcs_finish u_finish (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fin_valid_i   (fin_valid_q),
    .fin_i         (fin_q),
    .pseudo_i      (pseudo_q),
    .fin_ready_o   (fin_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Totals waiting on a stalled finishing stage must not change.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_valid_q && !fin_ready |=> fin_valid_q && $stable(fin_q))
    else $error("segment totals changed while stalled");

  // Closing a segment leaves the accumulator cleared for the next one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accum_fire && in_last_q |=> sum_q == '0 && cnt_q == '0 && field_q == '0)
    else $error("accumulator not cleared after last word");

  // An empty input register always takes a new transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> s_axis_tready)
    else $error("input stalled while input register empty");

  // A last word never leaves the input register without a result being queued.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accum_fire && in_last_q |=> fin_valid_q)
    else $error("last word lost before finishing stage");

endmodule

`default_nettype wire
